### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// types and constants shared by the blob centroid modules
// ----------------------------------------------------------------------------
package tbc_pkg;

  // pixel and gray conversion (bt.601, 14-bit fixed point, rounded)
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 14;
  localparam int PROD_W     = PIX_W + COEF_W;
  localparam int GRAY_SUM_W = PROD_W + 1;
  localparam int GRAY_SHIFT = 14;
  localparam int GRAY_W     = GRAY_SUM_W - GRAY_SHIFT;
  localparam logic [COEF_W-1:0]     COEF_RED   = COEF_W'(4899);
  localparam logic [COEF_W-1:0]     COEF_GREEN = COEF_W'(9617);
  localparam logic [COEF_W-1:0]     COEF_BLUE  = COEF_W'(1868);
  localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = GRAY_SUM_W'(8192);

  // accumulators and result fields
  localparam int COUNT_W = 23;
  localparam int SUM_W   = 34;
  localparam int CENT_W  = 15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  // configuration registers
  localparam int THRESH_W   = 8;
  localparam int AREA_LIM_W = 14;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [THRESH_W-1:0]   THRESH_RESET   = THRESH_W'(200);
  localparam logic [AREA_LIM_W-1:0] AREA_LIM_RESET = AREA_LIM_W'(100);

  // register index, taken from the word address bit
  typedef enum logic {
    REG_THRESH   = 1'b0,
    REG_AREA_LIM = 1'b1
  } reg_index_t;

  // stream packing
  localparam int IN_TDATA_W   = 3 * PIX_W;
  localparam int BLUE_LSB     = 0;
  localparam int GREEN_LSB    = PIX_W;
  localparam int RED_LSB      = 2 * PIX_W;
  localparam int CENT_X_LSB   = 0;
  localparam int CENT_Y_LSB   = CENT_W;
  localparam int AREA_LSB     = 2 * CENT_W;
  localparam int OUT_FIELDS_W = 2 * CENT_W + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [THRESH_W-1:0]   thresh;
    logic [AREA_LIM_W-1:0] area_limit;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;
  } dp_status_t;

endpackage

### rtl/core/threshold_blob_centroid.sv
// DIV_STEPS = clog2(max(MAX_WIDTH, MAX_HEIGHT)) + FRACTION_BITS (15 at defaults);
//   the end-of-frame item passes stage 1, stage 2, drain, divide and result load
// throughput: one pixel per cycle within a frame; after the end-of-frame item
//   the input stalls until the result is loaded, which waits on a previous result
// reset: synchronous, clears position, accumulators, sequencer and output valid;
//   threshold returns to 200 and minimum area to 100
// ----------------------------------------------------------------------------
// threshold_blob_centroid
// gray threshold on a bgr pixel stream, area and centroid of bright pixels per frame
// ----------------------------------------------------------------------------
module threshold_blob_centroid #(
  parameter int MAX_WIDTH     = 2048,
  parameter int MAX_HEIGHT    = 2048,
  parameter int FRACTION_BITS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // pixel stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tbc_pkg::IN_TDATA_W-1:0]    s_tdata,  // blue, green, red
  input  logic                              s_tlast,  // end_of_row
  input  logic                              s_tuser,  // end_of_frame
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tbc_pkg::OUT_TDATA_W-1:0]   m_tdata,  // centroid_x, centroid_y, area, zero pad
  output logic                              m_tuser,  // detected
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tbc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tbc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tbc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import tbc_pkg::*;

  localparam int XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DIV_STEPS = ((XW > YW) ? XW : YW) + FRACTION_BITS;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  tbc_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbc_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tbc_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .status  (status),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

### rtl/core/tbc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tbc_cfg_regs
// apb register file holding threshold and minimum area
// ----------------------------------------------------------------------------
module tbc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tbc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tbc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tbc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output tbc_pkg::cfg_t                     cfg
);
  import tbc_pkg::*;

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  // byte offset inside a word is ignored
  assign idx    = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thresh     <= THRESH_RESET;
      cfg.area_limit <= AREA_LIM_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_THRESH:   cfg.thresh     <= pwdata[THRESH_W-1:0];
        REG_AREA_LIM: cfg.area_limit <= pwdata[AREA_LIM_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESH:   prdata = APB_DATA_W'(cfg.thresh);
      REG_AREA_LIM: prdata = APB_DATA_W'(cfg.area_limit);
      default:      prdata = '0;
    endcase
  end

endmodule

### rtl/core/tbc_ctrl.sv
// ----------------------------------------------------------------------------
// tbc_ctrl
// frame sequencer: pixel intake, pipeline drain, divider steps, result hand-off
// ----------------------------------------------------------------------------
module tbc_ctrl #(
  parameter int DIV_STEPS = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tuser,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  tbc_pkg::dp_status_t   status,
  output tbc_pkg::ctrl_cmd_t    cmd
);
  import tbc_pkg::*;

  localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  typedef enum logic [3:0] {
    ST_ACCUM  = 4'b0001,
    ST_DRAIN  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_free;

  assign s_tready     = (state == ST_ACCUM);
  assign out_free     = !m_tvalid || m_tready;
  assign cmd.accept   = s_tvalid && s_tready;
  assign cmd.div_step = (state == ST_DIVIDE);
  assign cmd.load_out = (state == ST_FINISH) && out_free;

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_ACCUM: begin
        if (cmd.accept && s_tuser) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        // wait for the end-of-frame pixel to reach the accumulators
        if (status.frame_end) begin
          state_next = ST_DIVIDE;
          step_next  = '0;
        end
      end
      ST_DIVIDE: begin
        if (step == LAST_STEP) state_next = ST_FINISH;
        else step_next = step + STEP_W'(1);
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_ACCUM;
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACCUM;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

### rtl/core/tbc_datapath.sv
// ----------------------------------------------------------------------------
// tbc_datapath
// gray conversion pipeline, moment accumulators, radix-2 divider, result register
// ----------------------------------------------------------------------------
module tbc_datapath #(
  parameter int MAX_WIDTH     = 2048,
  parameter int MAX_HEIGHT    = 2048,
  parameter int FRACTION_BITS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tbc_pkg::cfg_t                     cfg,
  input  tbc_pkg::ctrl_cmd_t                cmd,
  output tbc_pkg::dp_status_t               status,
  input  logic [tbc_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  input  logic                              s_tuser,
  output logic [tbc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tuser
);
  import tbc_pkg::*;

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int QW = ((XW > YW) ? XW : YW) + FRACTION_BITS;
  localparam int DW = SUM_W + FRACTION_BITS;
  localparam logic [XW-1:0] X_LAST = XW'(MAX_WIDTH - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(MAX_HEIGHT - 1);
  localparam logic [QW-1:0] X_TOP  = QW'(MAX_WIDTH - 1) << FRACTION_BITS;
  localparam logic [QW-1:0] Y_TOP  = QW'(MAX_HEIGHT - 1) << FRACTION_BITS;

  // position of the next pixel
  logic [XW-1:0] col;
  logic [YW-1:0] row;

  // stage 1: weighted components
  logic              s1_valid, s1_eof;
  logic [PROD_W-1:0] s1_pr, s1_pg, s1_pb;
  logic [XW-1:0]     s1_x;
  logic [YW-1:0]     s1_y;

  // stage 2: foreground decision
  logic              s2_valid, s2_eof, s2_fg;
  logic [XW-1:0]     s2_x;
  logic [YW-1:0]     s2_y;
  logic [GRAY_SUM_W-1:0] gray_sum;
  logic [GRAY_W-1:0]     gray;

  // stage 3: accumulators
  logic [COUNT_W-1:0] count, count_next;
  logic [SUM_W-1:0]   xsum, xsum_next, ysum, ysum_next;
  logic [SUM_W:0]     xsum_add, ysum_add;
  logic               take;

  // divider
  logic [COUNT_W-1:0] divisor, rem_x, rem_y, rem_x_next, rem_y_next;
  logic [QW-1:0]      quo_x, quo_y, quo_x_next, quo_y_next;
  logic [DW-1:0]      dvd_x, dvd_y;
  logic [COUNT_W-1:0] dvd_x_hi, dvd_y_hi;
  logic [COUNT_W:0]   trial_x, trial_y;
  logic               det;
  logic [COUNT_W-1:0] area_hold;
  logic [QW-1:0]      cx_clamp, cy_clamp;

  // pixel position, updated on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.accept) begin
      if (s_tuser) begin
        col <= '0;
        row <= '0;
      end else if (s_tlast) begin
        col <= '0;
        if (row != Y_LAST) row <= row + YW'(1);
      end else if (col != X_LAST) begin
        col <= col + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_pr  <= PROD_W'(s_tdata[RED_LSB +: PIX_W]) * PROD_W'(COEF_RED);
    s1_pg  <= PROD_W'(s_tdata[GREEN_LSB +: PIX_W]) * PROD_W'(COEF_GREEN);
    s1_pb  <= PROD_W'(s_tdata[BLUE_LSB +: PIX_W]) * PROD_W'(COEF_BLUE);
    s1_eof <= s_tuser;
    s1_x   <= col;
    s1_y   <= row;
  end

  assign gray_sum = GRAY_SUM_W'(s1_pr) + GRAY_SUM_W'(s1_pg) + GRAY_SUM_W'(s1_pb) + GRAY_ROUND;
  assign gray     = gray_sum[GRAY_SUM_W-1:GRAY_SHIFT];

  always_ff @(posedge clk) begin
    s2_fg  <= gray > GRAY_W'(cfg.thresh);
    s2_eof <= s1_eof;
    s2_x   <= s1_x;
    s2_y   <= s1_y;
  end

  // saturating moment update
  assign take     = s2_valid && s2_fg && (count != COUNT_MAX);
  assign xsum_add = {1'b0, xsum} + (SUM_W + 1)'(s2_x);
  assign ysum_add = {1'b0, ysum} + (SUM_W + 1)'(s2_y);

  always_comb begin
    count_next = count;
    xsum_next  = xsum;
    ysum_next  = ysum;
    if (take) begin
      count_next = count + COUNT_W'(1);
      xsum_next  = xsum_add[SUM_W] ? SUM_MAX : xsum_add[SUM_W-1:0];
      ysum_next  = ysum_add[SUM_W] ? SUM_MAX : ysum_add[SUM_W-1:0];
    end
  end

  assign status.frame_end = s2_valid && s2_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      xsum  <= '0;
      ysum  <= '0;
    end else if (status.frame_end) begin
      count <= '0;
      xsum  <= '0;
      ysum  <= '0;
    end else begin
      count <= count_next;
      xsum  <= xsum_next;
      ysum  <= ysum_next;
    end
  end

  // the mean never exceeds the last position, so the quotient fits in QW bits
  // and the dividend bits above QW start out as a remainder below the divisor
  assign dvd_x    = DW'(xsum_next) << FRACTION_BITS;
  assign dvd_y    = DW'(ysum_next) << FRACTION_BITS;
  assign dvd_x_hi = COUNT_W'(dvd_x >> QW);
  assign dvd_y_hi = COUNT_W'(dvd_y >> QW);

  assign trial_x = {rem_x, quo_x[QW-1]};
  assign trial_y = {rem_y, quo_y[QW-1]};

  always_comb begin
    quo_x_next = QW'({quo_x, 1'b0});
    quo_y_next = QW'({quo_y, 1'b0});
    rem_x_next = trial_x[COUNT_W-1:0];
    rem_y_next = trial_y[COUNT_W-1:0];
    if (trial_x >= {1'b0, divisor}) begin
      rem_x_next    = COUNT_W'(trial_x - {1'b0, divisor});
      quo_x_next[0] = 1'b1;
    end
    if (trial_y >= {1'b0, divisor}) begin
      rem_y_next    = COUNT_W'(trial_y - {1'b0, divisor});
      quo_y_next[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (status.frame_end) begin
      divisor   <= count_next;
      area_hold <= count_next;
      det       <= count_next > COUNT_W'(cfg.area_limit);
      rem_x     <= dvd_x_hi;
      rem_y     <= dvd_y_hi;
      quo_x     <= dvd_x[QW-1:0];
      quo_y     <= dvd_y[QW-1:0];
    end else if (cmd.div_step) begin
      rem_x <= rem_x_next;
      rem_y <= rem_y_next;
      quo_x <= quo_x_next;
      quo_y <= quo_y_next;
    end
  end

  assign cx_clamp = (quo_x > X_TOP) ? X_TOP : quo_x;
  assign cy_clamp = (quo_y > Y_TOP) ? Y_TOP : quo_y;

  // result register, zeroed fields when nothing is detected
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tuser <= det;
      if (det) begin
        m_tdata <= OUT_TDATA_W'({area_hold, CENT_W'(cy_clamp), CENT_W'(cx_clamp)});
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

### rtl/core/tbc_checker.sv
// ----------------------------------------------------------------------------
// tbc_checker
// port-level checks on the blob centroid streams, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [tbc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic                              m_tuser
);
  import tbc_pkg::*;

  logic [OUT_TDATA_W:0] out_word;

  assign out_word = {m_tuser, m_tdata};

  // a stalled result keeps its payload
  `ASSERT_NEXT_CYCLE(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

  // no detection means every result field is zero
  `ASSERT_SAME_CYCLE(a_nodet_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)

  // a detection always carries a nonzero area
  `ASSERT_SAME_CYCLE(a_det_area, clk, rst, m_tvalid && m_tuser, m_tdata[AREA_LSB +: COUNT_W] != '0)

  // the end-of-frame item closes the input while the result is computed
  `ASSERT_NEXT_CYCLE(a_eof_stall, clk, rst, s_tvalid && s_tready && s_tuser, !s_tready)

endmodule

bind threshold_blob_centroid tbc_checker u_tbc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
